FILE: rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Shared types and constants for the running statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmvs_pkg;

   localparam int unsigned DataWidthDefault = 32;

   // sample item passed from the front part to the back part
   typedef struct packed {
      logic signed [31:0] sample;
   } smp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MUL,
      ST_UPDATE,
      ST_DIV_VAR,
      ST_SQRT,
      ST_OUT
   } exec_state_type;

endpackage

`default_nettype wire

FILE: rtl/running_mean_variance_stats_top.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats_top
// Online count, min, max, mean, variance and standard deviation of samples.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_sample (Q16.16)
// rsp     | out       | rsp_valid/rsp_ready  | count, min, max, mean, variance, std_dev
//
// Steps per item once past the first: take the item, the mean divide, the
// product, the update, the variance divide, the root (32 steps and a finishing
// step) and the output. The shared bit-serial divider sets the rate.
// The first item goes straight from being taken to the output.
// Reset: synchronous, clears all statistics; no clearing pass.
// Stalls: a two-item queue lets samples arrive while the back part works;
// a held result blocks only the next result, not the queue.
`default_nettype none

module running_mean_variance_stats_top #(
   parameter int unsigned DATA_WIDTH = rmvs_pkg::DataWidthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic signed [31:0]   req_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [31:0]               rsp_count,
   output logic signed [31:0]        rsp_minimum,
   output logic signed [31:0]        rsp_maximum,
   output logic signed [31:0]        rsp_mean,
   output logic [63:0]               rsp_variance,
   output logic [31:0]               rsp_std_dev
);
   import rmvs_pkg::*;

   logic    q_valid, q_ready;
   smp_type q_item;

   // front: take and sign-extend items
   rmvs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_sample,
      .q_valid, .q_ready, .q_item
   );

   // back: Welford update, divides and root
   rmvs_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .rsp_valid, .rsp_ready, .rsp_count, .rsp_minimum, .rsp_maximum,
      .rsp_mean, .rsp_variance, .rsp_std_dev
   );

endmodule

`default_nettype wire

FILE: rtl/rmvs_front.sv
// ----------------------------------------------------------------------------
// rmvs_front
// Accepts samples, sign-extends them from the data width and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_front #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [31:0]      req_sample,
   output logic                         q_valid,
   input  wire logic                    q_ready,
   output rmvs_pkg::smp_type            q_item
);
   import rmvs_pkg::*;

   // two-entry queue
   smp_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;
   smp_type    ext;

   always_comb begin
      ext.sample = 32'(signed'(req_sample[DATA_WIDTH-1:0]));
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("queue fill out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      fill_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      fill_ff == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/rmvs_back.sv
// ----------------------------------------------------------------------------
// rmvs_back
// Welford update with a shared bit-serial divider and a bit-pair root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmvs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire rmvs_pkg::smp_type     q_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [31:0]                rsp_count,
   output logic signed [31:0]         rsp_minimum,
   output logic signed [31:0]         rsp_maximum,
   output logic signed [31:0]         rsp_mean,
   output logic [63:0]                rsp_variance,
   output logic [31:0]                rsp_std_dev
);
   import rmvs_pkg::*;

   exec_state_type state_ff, state_in;

   logic [31:0]        count_ff;
   logic signed [31:0] min_ff, max_ff, mean_ff;
   logic [63:0]        sum_ff;
   logic signed [31:0] x_ff;
   logic signed [32:0] d1_ff;

   // shared restoring divider: quotient/remainder, 64-bit dividend max
   logic [63:0] dq_ff;     // dividend shifting into quotient
   logic [32:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [6:0]  step_ff;
   logic        neg_ff;

   // root unit
   logic [63:0] rv_ff;
   logic [63:0] rr_ff;
   logic [63:0] rbit_ff;

   logic        out_valid_ff;

   logic [33:0] rem_try;
   logic [32:0] rem_sh;
   logic        last_step;
   logic [31:0] cnt_new;
   logic [32:0] mag_d1;
   logic signed [33:0] new_mean;
   logic signed [33:0] d2;
   logic [32:0] mag_d2;
   logic [65:0] inc;
   logic [64:0] sum_add;
   logic [63:0] root_try;

   assign cnt_new   = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;
   assign rem_sh    = {rem_ff[31:0], dq_ff[63]};
   assign rem_try   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign last_step = (step_ff == 7'd0);
   assign mag_d1    = d1_ff[32] ? 33'(-d1_ff) : 33'(d1_ff);

   // quotient from divider is |d1|/count (< 2^33 fits in low bits)
   always_comb begin
      logic signed [33:0] q;
      q        = neg_ff ? -34'(signed'({1'b0, dq_ff[32:0]}))
                        : 34'(signed'({1'b0, dq_ff[32:0]}));
      new_mean = 34'(mean_ff) + q;
      d2       = 34'(x_ff) - new_mean;
      mag_d2   = d2[33] ? 33'(-d2) : 33'(d2);
   end

   always_ff @(posedge clock) begin
      inc <= 66'(mag_d1) * 66'(mag_d2);
   end

   assign sum_add  = {1'b0, sum_ff} + {1'b0, inc[63:0]};
   assign root_try = rr_ff + rbit_ff;

   assign q_ready   = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (q_valid) state_in = (count_ff == 32'd0) ? ST_OUT : ST_DIV_MEAN;
         ST_DIV_MEAN: if (last_step) state_in = ST_MUL;
         ST_MUL:      state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_DIV_VAR;
         ST_DIV_VAR:  if (last_step) state_in = ST_SQRT;
         ST_SQRT:     if (rbit_ff == 64'd0) state_in = ST_OUT;
         ST_OUT:      if (!out_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         min_ff <= '0; max_ff <= '0; mean_ff <= '0; sum_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid && rsp_ready && state_ff != ST_OUT) out_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (q_valid) begin
               x_ff     <= q_item.sample;
               count_ff <= cnt_new;
               if (count_ff == 32'd0 || q_item.sample < min_ff) min_ff <= q_item.sample;
               if (count_ff == 32'd0 || q_item.sample > max_ff) max_ff <= q_item.sample;
               d1_ff    <= 33'(q_item.sample) - 33'(mean_ff);
               if (count_ff == 32'd0) begin
                  mean_ff <= q_item.sample;
                  sum_ff  <= '0;
                  rv_ff   <= '0;   // variance zero, root zero
                  rr_ff   <= '0;
               end else begin
                  logic signed [32:0] dd;
                  dd      = 33'(q_item.sample) - 33'(mean_ff);
                  neg_ff  <= dd[32];
                  dq_ff   <= {31'd0, dd[32] ? 33'(-dd) : dd};
                  rem_ff  <= '0;
                  dvs_ff  <= cnt_new;
                  step_ff <= 7'd63;
               end
            end
            ST_DIV_MEAN, ST_DIV_VAR: begin
               if (!rem_try[33]) begin
                  rem_ff <= rem_try[32:0];
                  dq_ff  <= {dq_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  dq_ff  <= {dq_ff[62:0], 1'b0};
               end
               step_ff <= step_ff - 7'd1;
            end
            ST_UPDATE: begin
               // product registered during previous cycle
               logic [63:0] s;
               s       = (sum_add[64] || inc[65] || inc[64]) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                              : sum_add[63:0];
               sum_ff  <= s;
               mean_ff <= new_mean[31:0];
               dq_ff   <= s;
               rem_ff  <= '0;
               dvs_ff  <= count_ff - 32'd1;
               step_ff <= 7'd63;
            end
            ST_SQRT: begin
               if (rbit_ff != 64'd0) begin
                  if (rv_ff >= root_try) begin
                     rv_ff <= rv_ff - root_try;
                     rr_ff <= (rr_ff >> 1) + rbit_ff;
                  end else begin
                     rr_ff <= rr_ff >> 1;
                  end
                  rbit_ff <= rbit_ff >> 2;
               end
            end
            ST_OUT: if (!out_valid_ff || rsp_ready) begin
               out_valid_ff <= 1'b1;
               rsp_count    <= count_ff;
               rsp_minimum  <= min_ff;
               rsp_maximum  <= max_ff;
               rsp_mean     <= mean_ff;
               rsp_variance <= (count_ff == 32'd1) ? 64'd0 : dq_ff;
               rsp_std_dev  <= (count_ff == 32'd1) ? 32'd0 : rr_ff[31:0];
            end
            default: ;
         endcase
         if (state_ff == ST_DIV_VAR && last_step) begin
            // load root unit with the final quotient
            rv_ff   <= {dq_ff[62:0], ~rem_try[33]};
            rr_ff   <= '0;
            rbit_ff <= 64'h4000_0000_0000_0000;
         end
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> !q_ready) else $error("second item taken mid-update");
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count != 32'd0) else $error("result with zero count");
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_minimum <= rsp_maximum) else $error("min above max");

endmodule

`default_nettype wire
